[rtl/fpsc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Front panel scan controller package
// Shared types and constants for the channels and the controller core.
// ----------------------------------------------------------------------------
package fpsc_pkg;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_LED_PERIOD    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SCAN_RELOAD   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SETTLE_RELOAD = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_RELOAD = 2'd3;

  localparam logic [15:0] LED_PERIOD_RST    = 16'd1000;
  localparam logic [7:0]  SCAN_RELOAD_RST   = 8'd5;
  localparam logic [7:0]  SETTLE_RELOAD_RST = 8'd50;
  localparam logic [7:0]  SAMPLE_RELOAD_RST = 8'd10;

  localparam logic [3:0] ALL_RELEASED = 4'hF;
  localparam logic [7:0] KEY_MASK     = 8'hF0;

  localparam logic [2:0] CODE_NONE = 3'd0;
  localparam logic [2:0] CODE_BTN1 = 3'd1;
  localparam logic [2:0] CODE_BTN2 = 3'd2;
  localparam logic [2:0] CODE_BTN3 = 3'd3;
  localparam logic [2:0] CODE_BTN4 = 3'd4;

  typedef enum logic [1:0] {
    PRESS_IDLE,
    PRESS_SETTLE,
    PRESS_REPORT,
    PRESS_RELEASE
  } press_state_t;

  typedef struct packed {
    logic [7:0] port_sample;
    logic [3:0] button_pins;
    logic [3:0] digit_thousands;
    logic [3:0] digit_hundreds;
    logic [3:0] digit_tens;
    logic [3:0] digit_units;
  } in_item_t;

  typedef struct packed {
    logic [3:0] led_lines;
    logic [3:0] digit_enable;
    logic [3:0] digit_nibble;
    logic [2:0] button_code;
    logic [7:0] debounced_keys;
  } out_item_t;

  typedef struct packed {
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
  } cfg_write_t;

endpackage
`default_nettype wire

[rtl/fpsc_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Front panel scan controller channels
// Valid/ready channels for input requests, results and register writes.
// ----------------------------------------------------------------------------
interface fpsc_in_if;
  logic               valid;
  logic               ready;
  fpsc_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface fpsc_out_if;
  logic                valid;
  logic                ready;
  fpsc_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface fpsc_cfg_if;
  logic                 valid;
  logic                 ready;
  fpsc_pkg::cfg_write_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/front_panel_scan_controller_core.sv]
`default_nettype none
// A result is registered and valid the cycle after its request is accepted.
// Throughput: one request per cycle while results are taken; the single result register frees as it is taken.
// The panel state and the result register update in one pass per request.
// Reset (rst, synchronous): registers to defaults, all machines idle, no result.
// ----------------------------------------------------------------------------
// Front panel scan controller core
// LED rotator, display multiplexer, button reporter and port debouncer.
// ----------------------------------------------------------------------------
module front_panel_scan_controller_core (
  input  wire logic clk,
  input  wire logic rst,
  fpsc_cfg_if.sink  cfg,
  fpsc_in_if.sink   in_ch,
  fpsc_out_if.source out_ch
);

  logic [15:0] led_period;
  logic [7:0]  scan_reload, settle_reload, sample_reload;

  logic [1:0]  led_phase, led_phase_next;
  logic [15:0] led_timer, led_timer_next;
  logic [3:0]  led_levels, led_levels_next;
  logic [1:0]  scan_phase, scan_phase_next;
  logic [7:0]  scan_timer, scan_timer_next;
  logic [3:0]  shown_select, shown_select_next;
  logic [3:0]  shown_nibble, shown_nibble_next;
  fpsc_pkg::press_state_t press_state, press_state_next;
  logic [7:0]  press_timer, press_timer_next;
  logic [7:0]  stable_bits, stable_bits_next;
  logic [7:0]  vote_low, vote_low_next;
  logic [7:0]  vote_high, vote_high_next;
  logic [7:0]  sample_divider, sample_divider_next;
  logic [7:0]  keys_out, keys_out_next;
  logic [2:0]  code, code_next;
  logic        out_valid;
  logic        accept;

  logic [7:0]  delta;
  logic [3:0]  digit_sel;
  logic [7:0]  settle_start;

  function automatic logic [2:0] press_code(input logic [3:0] pins);
    if (!pins[3])      return fpsc_pkg::CODE_BTN4;
    else if (!pins[2]) return fpsc_pkg::CODE_BTN3;
    else if (!pins[1]) return fpsc_pkg::CODE_BTN2;
    else if (!pins[0]) return fpsc_pkg::CODE_BTN1;
    else               return fpsc_pkg::CODE_NONE;
  endfunction

  assign cfg.ready    = 1'b1;
  assign in_ch.ready  = !out_valid || out_ch.ready;
  assign accept       = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = '{led_lines: led_levels, digit_enable: shown_select,
                          digit_nibble: shown_nibble, button_code: code,
                          debounced_keys: keys_out};

  always_ff @(posedge clk) begin
    if (rst) begin
      led_period    <= fpsc_pkg::LED_PERIOD_RST;
      scan_reload   <= fpsc_pkg::SCAN_RELOAD_RST;
      settle_reload <= fpsc_pkg::SETTLE_RELOAD_RST;
      sample_reload <= fpsc_pkg::SAMPLE_RELOAD_RST;
    end else if (cfg.valid) begin
      unique case (cfg.data.index)
        fpsc_pkg::CFG_LED_PERIOD:    led_period    <= cfg.data.data;
        fpsc_pkg::CFG_SCAN_RELOAD:   scan_reload   <= cfg.data.data[7:0];
        fpsc_pkg::CFG_SETTLE_RELOAD: settle_reload <= cfg.data.data[7:0];
        fpsc_pkg::CFG_SAMPLE_RELOAD: sample_reload <= cfg.data.data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    led_phase_next      = led_phase;
    led_timer_next      = led_timer;
    led_levels_next     = led_levels;
    scan_phase_next     = scan_phase;
    scan_timer_next     = scan_timer;
    shown_select_next   = shown_select;
    shown_nibble_next   = shown_nibble;
    press_state_next    = press_state;
    press_timer_next    = press_timer;
    stable_bits_next    = stable_bits;
    vote_low_next       = vote_low;
    vote_high_next      = vote_high;
    sample_divider_next = sample_divider;
    keys_out_next       = keys_out;
    code_next           = fpsc_pkg::CODE_NONE;
    delta               = in_ch.data.port_sample ^ stable_bits;
    settle_start        = (settle_reload == 8'd0) ? 8'd0 : settle_reload - 8'd1;

    case (scan_phase)
      2'd0:    digit_sel = in_ch.data.digit_thousands;
      2'd1:    digit_sel = in_ch.data.digit_hundreds;
      2'd2:    digit_sel = in_ch.data.digit_tens;
      default: digit_sel = in_ch.data.digit_units;
    endcase

    // LED rotator
    if (led_timer == 16'd0) begin
      led_levels_next = led_levels ^ (4'd1 << led_phase);
      led_timer_next  = (led_period == 16'd0) ? 16'd0 : led_period - 16'd1;
      led_phase_next  = led_phase + 2'd1;
    end else begin
      led_timer_next  = led_timer - 16'd1;
    end

    // display multiplexer
    if (scan_timer == 8'd0) begin
      shown_select_next = 4'd1 << scan_phase;
      shown_nibble_next = digit_sel;
      scan_timer_next   = (scan_reload == 8'd0) ? 8'd0 : scan_reload - 8'd1;
      scan_phase_next   = scan_phase + 2'd1;
    end else begin
      scan_timer_next   = scan_timer - 8'd1;
    end

    // button machine
    if (press_timer != 8'd0) press_timer_next = press_timer - 8'd1;
    unique case (press_state)
      fpsc_pkg::PRESS_IDLE: begin
        if (in_ch.data.button_pins != fpsc_pkg::ALL_RELEASED) begin
          press_state_next = fpsc_pkg::PRESS_SETTLE;
          press_timer_next = settle_start;
        end
      end
      fpsc_pkg::PRESS_SETTLE: begin
        if (press_timer == 8'd0) press_state_next = fpsc_pkg::PRESS_REPORT;
      end
      fpsc_pkg::PRESS_REPORT: begin
        code_next        = press_code(in_ch.data.button_pins);
        press_timer_next = settle_start;
        press_state_next = fpsc_pkg::PRESS_RELEASE;
      end
      fpsc_pkg::PRESS_RELEASE: begin
        if (in_ch.data.button_pins == fpsc_pkg::ALL_RELEASED && press_timer == 8'd0)
          press_state_next = fpsc_pkg::PRESS_IDLE;
      end
      default: press_state_next = fpsc_pkg::PRESS_IDLE;
    endcase

    // vertical-counter debouncer
    if (sample_divider != 8'd0) begin
      sample_divider_next = sample_divider - 8'd1;
    end else begin
      sample_divider_next = sample_reload;
      vote_high_next      = (vote_high ^ vote_low) & delta;
      vote_low_next       = ~vote_low & delta;
      stable_bits_next    = stable_bits ^ (delta & ~(vote_low_next | vote_high_next));
      keys_out_next       = ~stable_bits_next & fpsc_pkg::KEY_MASK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      led_phase      <= 2'd0;
      led_timer      <= 16'd0;
      led_levels     <= 4'd0;
      scan_phase     <= 2'd0;
      scan_timer     <= 8'd0;
      shown_select   <= 4'd0;
      shown_nibble   <= 4'd0;
      press_state    <= fpsc_pkg::PRESS_IDLE;
      press_timer    <= 8'd0;
      stable_bits    <= 8'd0;
      vote_low       <= 8'd0;
      vote_high      <= 8'd0;
      sample_divider <= fpsc_pkg::SAMPLE_RELOAD_RST;
      keys_out       <= 8'd0;
      code           <= fpsc_pkg::CODE_NONE;
    end else if (accept) begin
      led_phase      <= led_phase_next;
      led_timer      <= led_timer_next;
      led_levels     <= led_levels_next;
      scan_phase     <= scan_phase_next;
      scan_timer     <= scan_timer_next;
      shown_select   <= shown_select_next;
      shown_nibble   <= shown_nibble_next;
      press_state    <= press_state_next;
      press_timer    <= press_timer_next;
      stable_bits    <= stable_bits_next;
      vote_low       <= vote_low_next;
      vote_high      <= vote_high_next;
      sample_divider <= sample_divider_next;
      keys_out       <= keys_out_next;
      code           <= code_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted request produced no result");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ch.ready) |=> (out_valid && $stable(out_ch.data)))
    else $error("stalled result changed");

  a_select_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(shown_select))
    else $error("display select not one-hot");

  a_report_once: assert property (@(posedge clk) disable iff (rst)
    (accept && press_state == fpsc_pkg::PRESS_REPORT)
      |=> press_state == fpsc_pkg::PRESS_RELEASE)
    else $error("report not followed by release wait");

  a_code_only_on_report: assert property (@(posedge clk) disable iff (rst)
    (accept && press_state != fpsc_pkg::PRESS_REPORT) |=> code == fpsc_pkg::CODE_NONE)
    else $error("button code outside report");

endmodule
`default_nettype wire

[verif/front_panel_scan_controller_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Front panel scan controller core testbench
// Drives timer-tick requests and register writes over valid/ready channels,
// predicts each LED, display, button and debounced-key readout tick for tick
// (fixed for the first directed rows), compares each result field by field.
// Directed rows run first, then random phases over several register settings.
// ----------------------------------------------------------------------------
module front_panel_scan_controller_core_tb;

  typedef struct packed {
    logic                typed;
    fpsc_pkg::out_item_t want;
    fpsc_pkg::in_item_t  stim;
  } dir_row_t;

  localparam fpsc_pkg::out_item_t NO_READOUT = '0;
  localparam int DIR_SPLIT = 4;
  localparam int DIR_ROWS_N = 24;
  localparam dir_row_t DIR_ROWS [DIR_ROWS_N] = '{
    {1'b1, {4'h1, 4'h1, 4'h9, fpsc_pkg::CODE_NONE, 8'h00}, {8'h00, 4'hF, 4'h9, 4'h8, 4'h7, 4'h6}},
    {1'b1, {4'h1, 4'h1, 4'h9, fpsc_pkg::CODE_NONE, 8'h00}, {8'hFF, 4'hF, 4'h0, 4'hF, 4'h0, 4'hF}},
    {1'b1, {4'h1, 4'h1, 4'h9, fpsc_pkg::CODE_NONE, 8'h00}, {8'hFF, 4'hF, 4'hF, 4'hF, 4'hF, 4'hF}},
    {1'b1, {4'h1, 4'h1, 4'h9, fpsc_pkg::CODE_NONE, 8'h00}, {8'h00, 4'hF, 4'h0, 4'h0, 4'h0, 4'h0}},
    {1'b0, NO_READOUT, {8'hFF, 4'h0, 4'h0, 4'hF, 4'h0, 4'hF}},
    {1'b0, NO_READOUT, {8'hFF, 4'h0, 4'hF, 4'h0, 4'hF, 4'h0}},
    {1'b0, NO_READOUT, {8'hFF, 4'h0, 4'h1, 4'h2, 4'h3, 4'h4}},
    {1'b0, NO_READOUT, {8'hFF, 4'hF, 4'h5, 4'h6, 4'h7, 4'h8}},
    {1'b0, NO_READOUT, {8'hFF, 4'hE, 4'h9, 4'hA, 4'hB, 4'hC}},
    {1'b0, NO_READOUT, {8'hFF, 4'hE, 4'hD, 4'hE, 4'hF, 4'h0}},
    {1'b0, NO_READOUT, {8'hFF, 4'hE, 4'hF, 4'hF, 4'hF, 4'hF}},
    {1'b0, NO_READOUT, {8'hFF, 4'hF, 4'h0, 4'h0, 4'h0, 4'h0}},
    {1'b0, NO_READOUT, {8'h00, 4'hD, 4'h3, 4'hC, 4'h5, 4'hA}},
    {1'b0, NO_READOUT, {8'h00, 4'hD, 4'hA, 4'h5, 4'hC, 4'h3}},
    {1'b0, NO_READOUT, {8'h00, 4'hD, 4'h1, 4'h8, 4'h2, 4'h4}},
    {1'b0, NO_READOUT, {8'h00, 4'hF, 4'h7, 4'hE, 4'hB, 4'hD}},
    {1'b0, NO_READOUT, {8'h00, 4'hB, 4'h6, 4'h9, 4'h6, 4'h9}},
    {1'b0, NO_READOUT, {8'h00, 4'hB, 4'hF, 4'h0, 4'hF, 4'h0}},
    {1'b0, NO_READOUT, {8'h00, 4'hB, 4'h2, 4'h4, 4'h8, 4'h1}},
    {1'b0, NO_READOUT, {8'h00, 4'hF, 4'hC, 4'h3, 4'hA, 4'h5}},
    {1'b0, NO_READOUT, {8'hA5, 4'h7, 4'h0, 4'h1, 4'h2, 4'h3}},
    {1'b0, NO_READOUT, {8'hA5, 4'hF, 4'h4, 4'h5, 4'h6, 4'h7}},
    {1'b0, NO_READOUT, {8'h5A, 4'hF, 4'h8, 4'h9, 4'hA, 4'hB}},
    {1'b0, NO_READOUT, {8'h5A, 4'hF, 4'hC, 4'hD, 4'hE, 4'hF}}
  };

  localparam int PHASES = 6;
  localparam int PHASE_TICKS = 190;

  logic clk = 1'b0;
  logic rst;

  fpsc_in_if  in_ch ();
  fpsc_out_if out_ch ();
  fpsc_cfg_if cfg_ch ();

  front_panel_scan_controller_core dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // panel model state
  logic [15:0]            led_period_q;
  logic [7:0]             scan_reload_q, settle_reload_q, sample_reload_q;
  logic [1:0]             led_step, scan_step;
  logic [15:0]            led_count;
  logic [3:0]             led_on, shown_en, shown_nib;
  logic [7:0]             scan_count, btn_count;
  fpsc_pkg::press_state_t btn_state;
  logic [7:0]             steady, vote_lo, vote_hi, sample_count, keys_q;

  fpsc_pkg::out_item_t pending_readouts [$];
  int unsigned         send_gap_pct, take_stall_pct;
  int unsigned         fail_count = 0;
  fpsc_pkg::out_item_t got, want;

  logic [3:0]  held_pins = fpsc_pkg::ALL_RELEASED;
  int unsigned hold_left = 0;
  logic [7:0]  port_level = 8'h00;

  function automatic void panel_reset();
    led_period_q    = fpsc_pkg::LED_PERIOD_RST;
    scan_reload_q   = fpsc_pkg::SCAN_RELOAD_RST;
    settle_reload_q = fpsc_pkg::SETTLE_RELOAD_RST;
    sample_reload_q = fpsc_pkg::SAMPLE_RELOAD_RST;
    led_step = '0; led_count = '0; led_on = '0;
    scan_step = '0; scan_count = '0; shown_en = '0; shown_nib = '0;
    btn_state = fpsc_pkg::PRESS_IDLE; btn_count = '0;
    steady = '0; vote_lo = '0; vote_hi = '0;
    sample_count = fpsc_pkg::SAMPLE_RELOAD_RST;
    keys_q = '0;
  endfunction

  function automatic fpsc_pkg::out_item_t panel_tick(fpsc_pkg::in_item_t s);
    logic [3:0]          digit [4];
    logic [7:0]          delta;
    fpsc_pkg::out_item_t r;
    digit[0] = s.digit_thousands;
    digit[1] = s.digit_hundreds;
    digit[2] = s.digit_tens;
    digit[3] = s.digit_units;
    r.button_code = fpsc_pkg::CODE_NONE;
    if (led_count == '0) begin
      led_on[led_step] = ~led_on[led_step];
      led_count = led_period_q;
      led_step = led_step + 2'd1;
    end
    if (scan_count == '0) begin
      shown_en = 4'b0001 << scan_step;
      shown_nib = digit[scan_step];
      scan_count = scan_reload_q;
      scan_step = scan_step + 2'd1;
    end
    case (btn_state)
      fpsc_pkg::PRESS_IDLE: begin
        if (s.button_pins != fpsc_pkg::ALL_RELEASED) begin
          btn_state = fpsc_pkg::PRESS_SETTLE;
          btn_count = settle_reload_q;
        end
      end
      fpsc_pkg::PRESS_SETTLE: begin
        if (btn_count == '0) btn_state = fpsc_pkg::PRESS_REPORT;
      end
      fpsc_pkg::PRESS_REPORT: begin
        if (!s.button_pins[3]) r.button_code = fpsc_pkg::CODE_BTN4;
        else if (!s.button_pins[2]) r.button_code = fpsc_pkg::CODE_BTN3;
        else if (!s.button_pins[1]) r.button_code = fpsc_pkg::CODE_BTN2;
        else if (!s.button_pins[0]) r.button_code = fpsc_pkg::CODE_BTN1;
        btn_count = settle_reload_q;
        btn_state = fpsc_pkg::PRESS_RELEASE;
      end
      default: begin
        if (s.button_pins == fpsc_pkg::ALL_RELEASED && btn_count == '0)
          btn_state = fpsc_pkg::PRESS_IDLE;
      end
    endcase
    if (scan_count != '0) scan_count = scan_count - 8'd1;
    if (btn_count != '0) btn_count = btn_count - 8'd1;
    if (led_count != '0) led_count = led_count - 16'd1;
    if (sample_count != '0) begin
      sample_count = sample_count - 8'd1;
    end else begin
      sample_count = sample_reload_q;
      delta = s.port_sample ^ steady;
      vote_hi = (vote_hi ^ vote_lo) & delta;
      vote_lo = ~vote_lo & delta;
      steady = steady ^ (delta & ~(vote_lo | vote_hi));
      keys_q = (steady ^ fpsc_pkg::KEY_MASK) & fpsc_pkg::KEY_MASK;
    end
    r.led_lines = led_on;
    r.digit_enable = shown_en;
    r.digit_nibble = shown_nib;
    r.debounced_keys = keys_q;
    return r;
  endfunction

  function automatic fpsc_pkg::in_item_t next_tick_stim();
    fpsc_pkg::in_item_t s;
    if (hold_left != 0) begin
      hold_left--;
    end else if (held_pins == fpsc_pkg::ALL_RELEASED) begin
      held_pins = 4'($urandom_range(14));
      hold_left = $urandom_range(settle_reload_q + 3);
    end else begin
      held_pins = fpsc_pkg::ALL_RELEASED;
      hold_left = $urandom_range(12);
    end
    s.button_pins = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : held_pins;
    if ($urandom_range(24) == 0) port_level = 8'($urandom);
    s.port_sample = port_level;
    if ($urandom_range(9) == 0) s.port_sample = port_level ^ (8'h01 << $urandom_range(7));
    s.digit_thousands = 4'($urandom_range(15));
    s.digit_hundreds  = 4'($urandom_range(15));
    s.digit_tens      = 4'($urandom_range(15));
    s.digit_units     = 4'($urandom_range(15));
    return s;
  endfunction

  task automatic send_tick(fpsc_pkg::in_item_t s, logic typed,
                           fpsc_pkg::out_item_t typed_want);
    fpsc_pkg::out_item_t r;
    while ($urandom_range(99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= s;
    do @(posedge clk); while (!in_ch.ready);
    r = panel_tick(s);
    pending_readouts.push_back(typed ? typed_want : r);
  endtask

  task automatic drain_readouts();
    in_ch.valid <= 1'b0;
    while (pending_readouts.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_panel(logic [15:0] led, logic [7:0] scan, logic [7:0] settle,
                           logic [7:0] sample);
    logic [fpsc_pkg::CFG_INDEX_W-1:0] idx [4];
    logic [15:0]                      val [4];
    idx = '{fpsc_pkg::CFG_LED_PERIOD, fpsc_pkg::CFG_SCAN_RELOAD,
            fpsc_pkg::CFG_SETTLE_RELOAD, fpsc_pkg::CFG_SAMPLE_RELOAD};
    val = '{led, {8'($urandom), scan}, {8'($urandom), settle}, {8'($urandom), sample}};
    cfg_ch.valid <= 1'b1;
    for (int k = 0; k < 4; k++) begin
      cfg_ch.data.index <= idx[k];
      cfg_ch.data.data  <= val[k];
      do @(posedge clk); while (!cfg_ch.ready);
      case (idx[k])
        fpsc_pkg::CFG_LED_PERIOD:    led_period_q    = val[k];
        fpsc_pkg::CFG_SCAN_RELOAD:   scan_reload_q   = val[k][7:0];
        fpsc_pkg::CFG_SETTLE_RELOAD: settle_reload_q = val[k][7:0];
        fpsc_pkg::CFG_SAMPLE_RELOAD: sample_reload_q = val[k][7:0];
        default: ;
      endcase
    end
    cfg_ch.valid <= 1'b0;
  endtask

  always @(posedge clk) out_ch.ready <= ($urandom_range(99) >= take_stall_pct);

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_readouts.size() == 0) begin
        $error("result arrived with nothing pending: %h", out_ch.data);
        fail_count++;
      end else begin
        want = pending_readouts.pop_front();
        got  = out_ch.data;
        if (got.led_lines !== want.led_lines) begin
          $error("led_lines expected %h got %h", want.led_lines, got.led_lines);
          fail_count++;
        end
        if (got.digit_enable !== want.digit_enable) begin
          $error("digit_enable expected %h got %h", want.digit_enable, got.digit_enable);
          fail_count++;
        end
        if (got.digit_nibble !== want.digit_nibble) begin
          $error("digit_nibble expected %h got %h", want.digit_nibble, got.digit_nibble);
          fail_count++;
        end
        if (got.button_code !== want.button_code) begin
          $error("button_code expected %0d got %0d", want.button_code, got.button_code);
          fail_count++;
        end
        if (got.debounced_keys !== want.debounced_keys) begin
          $error("debounced_keys expected %h got %h", want.debounced_keys,
                 got.debounced_keys);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    send_gap_pct = 28;
    take_stall_pct = 46;
    panel_reset();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS_N; i++) begin
      if (i == DIR_SPLIT) begin
        drain_readouts();
        set_panel(16'd0, 8'd0, 8'd0, 8'd0);
      end
      send_tick(DIR_ROWS[i].stim, DIR_ROWS[i].typed, DIR_ROWS[i].want);
    end
    drain_readouts();

    for (int ph = 0; ph < PHASES; ph++) begin
      send_gap_pct   = (ph < 2) ? 28 : (ph < 4) ? 46 : 0;
      take_stall_pct = (ph < 2) ? 46 : (ph < 4) ? 28 : 0;
      case (ph)
        0: set_panel(16'd3, 8'd1, 8'd4, 8'd2);
        1: set_panel(16'd0, 8'd0, 8'd0, 8'd0);
        2: set_panel(16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
        3: set_panel(16'($urandom_range(20)), 8'($urandom_range(7)),
                     8'($urandom_range(7)), 8'($urandom_range(7)));
        4: set_panel(16'($urandom_range(8)), 8'($urandom_range(3)),
                     8'($urandom_range(12)), 8'($urandom_range(3)));
        default: set_panel(16'($urandom), 8'($urandom), 8'($urandom_range(10)),
                           8'($urandom));
      endcase
      for (int i = 0; i < PHASE_TICKS; i++) begin
        if (i == PHASE_TICKS / 2) drain_readouts();
        send_tick(next_tick_stim(), 1'b0, NO_READOUT);
      end
      drain_readouts();
    end

    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
